### rtl/aapr_pkg.sv
// Shared types and constants of the axis-angle point rotation block.
package aapr_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = 33;
  localparam int AxisW  = 18;
  localparam int AngW   = 16;
  localparam int TrigW  = 18;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X   = 3'd3;
  localparam logic [2:0] REG_AXIS_Y   = 3'd4;
  localparam logic [2:0] REG_AXIS_Z   = 3'd5;

  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42048;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [17:0] ONE_Q16 = 18'd65536;
  localparam logic [14:0] QUARTER = 15'd16384;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  // Cyclic neighbours for the cross product.
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef struct packed {
    logic signed [CoordW-1:0] org_x;
    logic signed [CoordW-1:0] org_y;
    logic signed [CoordW-1:0] org_z;
    logic signed [AxisW-1:0]  ax_x;
    logic signed [AxisW-1:0]  ax_y;
    logic signed [AxisW-1:0]  ax_z;
  } cfg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] v_x;
    logic signed [DiffW-1:0] v_y;
    logic signed [DiffW-1:0] v_z;
    logic signed [TrigW-1:0] sn;
    logic signed [TrigW-1:0] cs;
  } item_t;

endpackage

### rtl/aapr_front.sv
// Front part: takes items, forms the offset vector and evaluates sine and cosine.
module aapr_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic signed [aapr_pkg::CoordW-1:0] point_x,
  input  logic signed [aapr_pkg::CoordW-1:0] point_y,
  input  logic signed [aapr_pkg::CoordW-1:0] point_z,
  input  logic [aapr_pkg::AngW-1:0]         rotation_angle,
  input  aapr_pkg::cfg_t                    cfg,
  input  logic                              q_full,
  output logic                              push,
  output aapr_pkg::item_t                   push_item
);

  logic                  en;
  logic [4:0]            vld_r;
  logic [4:0]            vld_nxt;
  logic signed [32:0]    v_r [5][3];
  logic [14:0]           z_r [5][2];
  logic                  neg_r [5][2];
  logic [14:0]           z2_r [2];
  logic [14:0]           z2d_r [2];
  logic [15:0]           t1_r [2];
  logic [16:0]           t2_r [2];
  logic signed [17:0]    s_r [2];
  logic [15:0]           ang [2];
  logic [29:0]           pz [2];
  logic [27:0]           pc [2];
  logic [30:0]           pt [2];
  logic [31:0]           ps [2];
  logic [17:0]           mag [2];

  assign en        = !vld_r[4] || !q_full;
  assign in_tready = en;
  assign push      = vld_r[4] && !q_full;
  assign vld_nxt   = {vld_r[3:0], in_tvalid};

  always_comb begin
    ang[0] = rotation_angle;
    ang[1] = rotation_angle + 16'd16384;
    for (int i = 0; i < 2; i++) begin
      pz[i]  = 30'(z_r[0][i]) * 30'(z_r[0][i]);
      pc[i]  = 28'(z2_r[i]) * 28'(aapr_pkg::SIN_C);
      pt[i]  = 31'(z2d_r[i]) * 31'(t1_r[i]);
      ps[i]  = 32'(z_r[3][i]) * 32'(t2_r[i]);
      mag[i] = (ps[i][31:14] > aapr_pkg::ONE_Q16) ? aapr_pkg::ONE_Q16 : ps[i][31:14];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0][0] <= 33'(point_x) - 33'(cfg.org_x);
      v_r[0][1] <= 33'(point_y) - 33'(cfg.org_y);
      v_r[0][2] <= 33'(point_z) - 33'(cfg.org_z);
      for (int i = 0; i < 2; i++) begin
        z_r[0][i]   <= ang[i][14] ? (aapr_pkg::QUARTER - {1'b0, ang[i][13:0]})
                                  : {1'b0, ang[i][13:0]};
        neg_r[0][i] <= ang[i][15];
        z2_r[i]     <= pz[i][28:14];
        z2d_r[i]    <= z2_r[i];
        t1_r[i]     <= aapr_pkg::SIN_B - {2'b00, pc[i][27:14]};
        t2_r[i]     <= aapr_pkg::SIN_A - pt[i][30:14];
        s_r[i]      <= neg_r[3][i] ? -$signed(mag[i]) : $signed(mag[i]);
      end
      for (int s = 1; s < 5; s++) begin
        v_r[s]   <= v_r[s-1];
        z_r[s]   <= z_r[s-1];
        neg_r[s] <= neg_r[s-1];
      end
    end
  end

  always_comb begin
    push_item.v_x = v_r[4][0];
    push_item.v_y = v_r[4][1];
    push_item.v_z = v_r[4][2];
    push_item.sn  = s_r[0];
    push_item.cs  = s_r[1];
  end

endmodule

### rtl/aapr_fifo.sv
// Short queue that parts the front and back pipelines.
module aapr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aapr_pkg::item_t push_item,
  input  logic            pop,
  output aapr_pkg::item_t pop_item,
  output logic            full,
  output logic            empty
);

  aapr_pkg::item_t              mem [aapr_pkg::FifoDepth];
  logic [aapr_pkg::FifoAw-1:0]  wp_r;
  logic [aapr_pkg::FifoAw-1:0]  rp_r;
  logic [aapr_pkg::FifoAw:0]    cnt_r;
  logic [aapr_pkg::FifoAw:0]    cnt_nxt;

  assign full     = cnt_r == (aapr_pkg::FifoAw+1)'(aapr_pkg::FifoDepth);
  assign empty    = cnt_r == '0;
  assign pop_item = mem[rp_r];
  assign cnt_nxt  = cnt_r + (aapr_pkg::FifoAw+1)'(push) - (aapr_pkg::FifoAw+1)'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue read while empty");
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[aapr_pkg::FifoAw-1:0]) else $error("queue count mismatch");
`endif

endmodule

### rtl/aapr_back.sv
// Back part: multiply pipeline that evaluates the rotation and saturates.
module aapr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  output logic                              pop,
  input  aapr_pkg::item_t                   item,
  input  aapr_pkg::cfg_t                    cfg,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata
);

  logic               en;
  logic [5:0]         vld_r;
  logic signed [32:0] v [3];
  logic signed [17:0] a [3];
  logic signed [31:0] o [3];
  logic signed [50:0] pa_r [3];
  logic signed [50:0] pb_r [3];
  logic signed [50:0] pd_r [3];
  logic signed [50:0] vc1_r [3];
  logic signed [50:0] vc2_r [3];
  logic signed [50:0] vc3_r [3];
  logic signed [17:0] sn1_r, sn2_r, cs1_r;
  logic signed [35:0] cr_r [3];
  logic signed [36:0] dot_r;
  logic signed [18:0] om_r;
  logic signed [53:0] csn_r [3];
  logic signed [55:0] kp_r;
  logic signed [54:0] sum_r [3];
  logic signed [39:0] k_r;
  logic signed [54:0] sum2_r [3];
  logic signed [57:0] ak_r [3];
  logic signed [51:0] dif [3];
  logic signed [52:0] dsum;
  logic signed [59:0] tot [3];
  logic signed [44:0] res [3];
  logic [31:0]        sat [3];
  logic [95:0]        out_r;

  function automatic int NXT1_I(input int i);
    return aapr_pkg::NXT1[i];
  endfunction

  function automatic int NXT2_I(input int i);
    return aapr_pkg::NXT2[i];
  endfunction

  assign en         = !vld_r[5] || out_tready;
  assign pop        = en && !q_empty;
  assign out_tvalid = vld_r[5];
  assign out_tdata  = out_r;

  assign v[0] = item.v_x;
  assign v[1] = item.v_y;
  assign v[2] = item.v_z;
  assign a[0] = cfg.ax_x;
  assign a[1] = cfg.ax_y;
  assign a[2] = cfg.ax_z;
  assign o[0] = cfg.org_x;
  assign o[1] = cfg.org_y;
  assign o[2] = cfg.org_z;

  always_comb begin
    dsum = 53'(pd_r[0]) + 53'(pd_r[1]) + 53'(pd_r[2]);
    for (int i = 0; i < 3; i++) begin
      dif[i] = 52'(pa_r[i]) - 52'(pb_r[i]);
      tot[i] = 60'(sum2_r[i]) + 60'(ak_r[i]) + 60'sd32768;
      res[i] = 45'($signed(tot[i][59:16])) + 45'(o[i]);
      if (res[i] > 45'sd2147483647) begin
        sat[i] = 32'h7FFF_FFFF;
      end else if (res[i] < -45'sd2147483648) begin
        sat[i] = 32'h8000_0000;
      end else begin
        sat[i] = res[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i]   <= a[NXT1_I(i)] * v[NXT2_I(i)];
        pb_r[i]   <= a[NXT2_I(i)] * v[NXT1_I(i)];
        pd_r[i]   <= a[i] * v[i];
        vc1_r[i]  <= v[i] * item.cs;
        cr_r[i]   <= dif[i][51:16];
        vc2_r[i]  <= vc1_r[i];
        csn_r[i]  <= cr_r[i] * sn2_r;
        vc3_r[i]  <= vc2_r[i];
        sum_r[i]  <= 55'(vc3_r[i]) + 55'(csn_r[i]);
        sum2_r[i] <= sum_r[i];
        ak_r[i]   <= a[i] * k_r;
      end
      sn1_r <= item.sn;
      cs1_r <= item.cs;
      sn2_r <= sn1_r;
      dot_r <= dsum[52:16];
      om_r  <= 19'sd65536 - 19'(cs1_r);
      kp_r  <= dot_r * om_r;
      k_r   <= kp_r[55:16];
      out_r <= {sat[2], sat[1], sat[0]};
    end
  end

endmodule

### rtl/axis_angle_point_rotation.sv
// Throughput: one item per cycle while the output is not stalled.
// Five front stages, a four-entry queue and six back stages lie between input and output.
// The output register takes a new result whenever it is empty or being taken.
// Reset (rst_n low, synchronous) empties all stages and the queue, sets the origin
// to zero and the axis to +z; no clearing pass is needed.
// Top level of the axis-angle point rotation block.
module axis_angle_point_rotation (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // point_x, point_y, point_z, rotation_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // rotated_x, rotated_y, rotated_z
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // Configuration registers; to be written only while the block is idle, which the block itself does not enforce.
  aapr_pkg::cfg_t  cfg_r;
  aapr_pkg::item_t push_item;
  aapr_pkg::item_t pop_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org_x <= '0;
      cfg_r.org_y <= '0;
      cfg_r.org_z <= '0;
      cfg_r.ax_x  <= '0;
      cfg_r.ax_y  <= '0;
      cfg_r.ax_z  <= aapr_pkg::ONE_Q16;
    end else if (cfg_valid) begin
      case (cfg_index)
        aapr_pkg::REG_ORIGIN_X: cfg_r.org_x <= cfg_data;
        aapr_pkg::REG_ORIGIN_Y: cfg_r.org_y <= cfg_data;
        aapr_pkg::REG_ORIGIN_Z: cfg_r.org_z <= cfg_data;
        aapr_pkg::REG_AXIS_X:   cfg_r.ax_x  <= cfg_data[17:0];
        aapr_pkg::REG_AXIS_Y:   cfg_r.ax_y  <= cfg_data[17:0];
        aapr_pkg::REG_AXIS_Z:   cfg_r.ax_z  <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // The front computes the offset vector and the sine and cosine of the angle.
  aapr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .point_x        (in_tdata[31:0]),
    .point_y        (in_tdata[63:32]),
    .point_z        (in_tdata[95:64]),
    .rotation_angle (in_tdata[111:96]),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  aapr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back applies the rotation formula and adds the origin back.
  aapr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .pop        (pop),
    .item       (pop_item),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### tb/sv/axis_angle_point_rotation_tb.sv
// Testbench for the axis-angle point rotation block: predicted results checked item by item.
module axis_angle_point_rotation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // Scoreboard: holds the rotation settings, predicts each rotated point and checks results.
  class rotation_scoreboard;
    logic signed [31:0] org [3];
    logic signed [17:0] ax [3];
    point_t pending [$];
    int errors;

    function new();
      org = '{0, 0, 0};
      ax = '{0, 0, 18'sd65536};
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        aapr_pkg::REG_ORIGIN_X: org[0] = val;
        aapr_pkg::REG_ORIGIN_Y: org[1] = val;
        aapr_pkg::REG_ORIGIN_Z: org[2] = val;
        aapr_pkg::REG_AXIS_X:   ax[0] = val[17:0];
        aapr_pkg::REG_AXIS_Y:   ax[1] = val[17:0];
        aapr_pkg::REG_AXIS_Z:   ax[2] = val[17:0];
        default: ;
      endcase
    endfunction

    // Polynomial sine of a binary angle, Q16, exact to the block's arithmetic.
    function longint sine_q16(logic [15:0] ang);
      logic [1:0] quad;
      longint z, z2, s;
      quad = ang[15:14];
      z = quad[0] ? (16384 - longint'(ang[13:0])) : longint'(ang[13:0]);
      z2 = (z * z) >>> 14;
      s = (z2 * 4640) >>> 14;
      s = (z2 * (42048 - s)) >>> 14;
      s = (z * (102944 - s)) >>> 14;
      if (s > 65536) s = 65536;
      return quad[1] ? -s : s;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_point(logic [111:0] d);
      longint v [3], a [3], o [3], c [3], r [3];
      longint sn, cs, dot, k;
      point_t p;
      for (int i = 0; i < 3; i++) begin
        o[i] = org[i];
        a[i] = ax[i];
        v[i] = longint'($signed(d[32*i +: 32])) - o[i];
      end
      sn = sine_q16(d[111:96]);
      cs = sine_q16(d[111:96] + 16'd16384);
      for (int i = 0; i < 3; i++)
        c[i] = (a[(i+1)%3] * v[(i+2)%3] - a[(i+2)%3] * v[(i+1)%3]) >>> 16;
      dot = (a[0] * v[0] + a[1] * v[1] + a[2] * v[2]) >>> 16;
      k = (dot * (65536 - cs)) >>> 16;
      for (int i = 0; i < 3; i++)
        r[i] = ((v[i] * cs + c[i] * sn + a[i] * k + 32768) >>> 16) + o[i];
      p.x = clamp32(r[0]);
      p.y = clamp32(r[1]);
      p.z = clamp32(r[2]);
      pending.insert(pending.size(), p);
    endfunction

    function void check_point(logic [95:0] d);
      point_t e;
      if (pending.size() == 0) begin
        $error("result item with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if ($signed(d[31:0]) !== e.x) begin
        $error("rotated_x expected %0d actual %0d", e.x, $signed(d[31:0])); errors++;
      end
      if ($signed(d[63:32]) !== e.y) begin
        $error("rotated_y expected %0d actual %0d", e.y, $signed(d[63:32])); errors++;
      end
      if ($signed(d[95:64]) !== e.z) begin
        $error("rotated_z expected %0d actual %0d", e.z, $signed(d[95:64])); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rotation_scoreboard sb = new();
  bit calm;          // set in the final part of the run: no idling on either side
  int quiet_cycles;

  always #4 clk = ~clk;

  axis_angle_point_rotation i_dut (.*);

  // Input and result acceptance are observed at the same edge on which they happen.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_point(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_point(out_tdata);
  end

  // Watchdog: counts cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("** axis_angle_point_rotation: FAILED **");
      $finish;
    end
  end

  // Receiver: stalls in random bursts, and never once the run is calm.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Writes one register; the channel drops for a cycle afterwards.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one point; the sender may idle for a burst before it.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [15:0] ang);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ang, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;  // near zero
      default: return $urandom;
    endcase
  endfunction

  // Unit-ish axis from a handful of shapes, extremes and out-of-range codes included.
  task automatic set_axis(int shape);
    logic [17:0] a [3];
    case (shape)
      0: a = '{18'd65536, 18'd0, 18'd0};
      1: a = '{18'd0, -18'sd65536, 18'd0};
      2: a = '{18'd37837, 18'd37837, 18'd37837};  // diagonal, roughly unit
      3: a = '{18'h20000, 18'h1ffff, 18'd46341};  // outside the unit range
      default: a = '{18'($urandom), 18'($urandom), 18'($urandom)};
    endcase
    write_reg(aapr_pkg::REG_AXIS_X, {{14{a[0][17]}}, a[0]});
    write_reg(aapr_pkg::REG_AXIS_Y, {{14{a[1][17]}}, a[1]});
    write_reg(aapr_pkg::REG_AXIS_Z, {{14{a[2][17]}}, a[2]});
  endtask

  initial begin
    logic [15:0] angs [8];
    angs = '{16'd0, 16'd16384, 16'd32768, 16'd49152,
             16'd65535, 16'd1, 16'd16383, 16'd8192};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset axis (+z), angle extremes and quadrant edges, coordinate extremes.
    foreach (angs[i]) send_point(32'h00010000, 32'h7fffffff, 32'h80000000, angs[i]);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd8192);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'd40000);
    send_point(32'h0, 32'h0, 32'h0, 16'hffff);
    drain();
    // An unknown register index must be ignored.
    write_reg(3'd7, 32'hffffffff);
    write_reg(3'd6, 32'h12345678);
    write_reg(aapr_pkg::REG_ORIGIN_X, 32'h7fffffff);
    write_reg(aapr_pkg::REG_ORIGIN_Y, 32'h80000000);
    write_reg(aapr_pkg::REG_ORIGIN_Z, 32'h00050000);
    set_axis(3);
    send_point(32'h80000000, 32'h7fffffff, 32'h0, 16'd12345);
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 16'd50000);
    drain();

    // Random phases, each with its own settings; the sender drains between them.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 8) calm = 1'b1;
      write_reg(aapr_pkg::REG_ORIGIN_X, (ph % 3 == 0) ? 32'h0 : rand_coord());
      write_reg(aapr_pkg::REG_ORIGIN_Y, (ph % 3 == 0) ? 32'h0 : rand_coord());
      write_reg(aapr_pkg::REG_ORIGIN_Z, (ph % 3 == 0) ? 32'h0 : rand_coord());
      set_axis(ph % 6);
      repeat (185) send_point(rand_coord(), rand_coord(), rand_coord(), $urandom);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** axis_angle_point_rotation: PASSED **");
    else
      $display("** axis_angle_point_rotation: FAILED **");
    $finish;
  end
endmodule

### axis_angle_point_rotation.f
rtl/aapr_pkg.sv
rtl/aapr_front.sv
rtl/aapr_fifo.sv
rtl/aapr_back.sv
rtl/axis_angle_point_rotation.sv
tb/sv/axis_angle_point_rotation_tb.sv
